FILE: rtl/dme_pkg.sv
// ----------------------------------------------------------------------------
// dme_pkg
// shared types, constants and helper functions of the decimal morse encoder
// ----------------------------------------------------------------------------
package dme_pkg;

    localparam int NUM_DIGITS      = 8;
    localparam int DIGIT_W         = 4;
    localparam int BCD_W           = NUM_DIGITS * DIGIT_W;
    localparam int INPUT_W         = 32;
    localparam int CNT_W           = $clog2(INPUT_W);
    localparam int IDX_W           = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int LEN_W           = 16;
    localparam int MARKS_PER_DIGIT = 5;
    localparam int POS_W           = 3;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_INDEX_W     = 3;

    localparam logic [LEN_W-1:0] DOT_LENGTH_RST  = 16'd100;
    localparam logic [LEN_W-1:0] DASH_LENGTH_RST = 16'd300;
    localparam logic [LEN_W-1:0] ELEM_GAP_RST    = 16'd100;
    localparam logic [LEN_W-1:0] DIGIT_GAP_RST   = 16'd300;
    localparam logic [LEN_W-1:0] END_GAP_RST     = 16'd1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DOT_LENGTH  = 3'd0,
        REG_DASH_LENGTH = 3'd1,
        REG_ELEMENT_GAP = 3'd2,
        REG_DIGIT_GAP   = 3'd3,
        REG_END_GAP     = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [LEN_W-1:0] dot_length;
        logic [LEN_W-1:0] dash_length;
        logic [LEN_W-1:0] element_gap;
        logic [LEN_W-1:0] digit_gap;
        logic [LEN_W-1:0] end_gap;
    } cfg_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               final_digit;
    } digit_entry_t;

    typedef enum logic [1:0] {
        FRONT_IDLE    = 2'd0,
        FRONT_CONVERT = 2'd1,
        FRONT_PUSH    = 2'd2
    } front_state_t;

    // itu digits: 0..5 start with d dots, 6..9 start with d-5 dashes
    function automatic logic mark_is_dash(input logic [DIGIT_W-1:0] d,
                                          input logic [POS_W-1:0]   pos);
        logic [DIGIT_W-1:0] pos_ext;
        logic [DIGIT_W-1:0] d_minus;
        pos_ext = DIGIT_W'(pos);
        d_minus = DIGIT_W'(d - DIGIT_W'(5));
        if (d <= DIGIT_W'(5))
        begin
            return pos_ext >= d;
        end
        return pos_ext < d_minus;
    endfunction

    // double dabble correction of one bcd digit
    function automatic logic [DIGIT_W-1:0] dabble_adjust(input logic [DIGIT_W-1:0] d);
        if (d >= DIGIT_W'(5))
        begin
            return DIGIT_W'(d + DIGIT_W'(3));
        end
        return d;
    endfunction

endpackage

FILE: rtl/dme_front.sv
// ----------------------------------------------------------------------------
// dme_front
// takes a number, converts it to bcd one bit per cycle, drops leading zeros
// and pushes the kept digits into the digit queue
// ----------------------------------------------------------------------------
module dme_front
    import dme_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [INPUT_W-1:0]  number_value,
    output logic                push,
    output digit_entry_t        push_entry,
    input  logic                queue_full
);

    front_state_t       state_reg, state_next;
    logic [INPUT_W-1:0] shift_reg, shift_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               lead_reg, lead_next;

    logic [BCD_W-1:0]   adjusted;
    logic [DIGIT_W-1:0] cur_digit;
    logic               cur_final;
    logic               skip;
    logic               last_bit;

    always_comb
    begin
        for (int k = 0; k < NUM_DIGITS; k++)
        begin
            adjusted[k*DIGIT_W +: DIGIT_W] = dabble_adjust(bcd_reg[k*DIGIT_W +: DIGIT_W]);
        end
    end

    assign cur_digit = bcd_reg[idx_reg*DIGIT_W +: DIGIT_W];
    assign cur_final = (idx_reg == '0);
    assign skip      = lead_reg && (cur_digit == '0) && !cur_final;
    assign last_bit  = (bit_cnt_reg == CNT_W'(INPUT_W - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FRONT_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = FRONT_CONVERT;
                end
            end
            FRONT_CONVERT:
            begin
                if (last_bit)
                begin
                    state_next = FRONT_PUSH;
                end
            end
            FRONT_PUSH:
            begin
                if (!skip && !queue_full && cur_final)
                begin
                    state_next = FRONT_IDLE;
                end
            end
            default:
            begin
                state_next = FRONT_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_stall               = (state_reg != FRONT_IDLE);
        push                   = (state_reg == FRONT_PUSH) && !skip && !queue_full;
        push_entry.digit       = cur_digit;
        push_entry.final_digit = cur_final;
    end

    // datapath
    always_comb
    begin
        shift_next   = shift_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        idx_next     = idx_reg;
        lead_next    = lead_reg;
        unique case (state_reg)
            FRONT_IDLE:
            begin
                if (in_valid)
                begin
                    shift_next   = number_value;
                    bcd_next     = '0;
                    bit_cnt_next = '0;
                end
            end
            FRONT_CONVERT:
            begin
                bcd_next     = {adjusted[BCD_W-2:0], shift_reg[INPUT_W-1]};
                shift_next   = {shift_reg[INPUT_W-2:0], 1'b0};
                bit_cnt_next = CNT_W'(bit_cnt_reg + 1'b1);
                idx_next     = IDX_W'(NUM_DIGITS - 1);
                lead_next    = 1'b1;
            end
            FRONT_PUSH:
            begin
                if (skip)
                begin
                    idx_next = IDX_W'(idx_reg - 1'b1);
                end
                else if (!queue_full)
                begin
                    lead_next = 1'b0;
                    idx_next  = IDX_W'(idx_reg - 1'b1);
                end
            end
            default:
            begin
                lead_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= FRONT_IDLE;
            bit_cnt_reg <= '0;
            idx_reg     <= '0;
            lead_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            idx_reg     <= idx_next;
            lead_reg    <= lead_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        bcd_reg   <= bcd_next;
    end

    ap_no_skip_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FRONT_PUSH && cur_final) |-> !skip)
        else $error("final digit skipped");

endmodule

FILE: rtl/dme_queue.sv
// ----------------------------------------------------------------------------
// dme_queue
// small fifo of digits between the converter and the mark generator
// ----------------------------------------------------------------------------
module dme_queue
    import dme_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  digit_entry_t push_entry,
    output logic         full,
    input  logic         pop,
    output logic         empty,
    output digit_entry_t head
);

    digit_entry_t      entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = QCNT_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = QCNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    ap_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

    ap_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");

    ap_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("pop from empty queue");

endmodule

FILE: rtl/dme_back.sv
// ----------------------------------------------------------------------------
// dme_back
// turns each queued digit into five marks and holds them in the output register
// ----------------------------------------------------------------------------
module dme_back
    import dme_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               queue_empty,
    input  digit_entry_t       head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [LEN_W-1:0]   mark_length,
    output logic [LEN_W-1:0]   space_length,
    output logic [DIGIT_W-1:0] digit_sent,
    output logic               is_dash,
    output logic               last_mark
);

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               out_valid_reg, out_valid_next;
    logic [LEN_W-1:0]   mark_length_reg, mark_length_next;
    logic [LEN_W-1:0]   space_length_reg, space_length_next;
    logic [DIGIT_W-1:0] digit_sent_reg;
    logic               is_dash_reg, is_dash_next;
    logic               last_mark_reg, last_mark_next;

    logic load;
    logic last_in_digit;

    assign load          = !queue_empty && (!out_valid_reg || !out_stall);
    assign last_in_digit = (pos_reg == POS_W'(MARKS_PER_DIGIT - 1));
    assign pop           = load && last_in_digit;

    always_comb
    begin
        is_dash_next     = mark_is_dash(head.digit, pos_reg);
        last_mark_next   = head.final_digit && last_in_digit;
        mark_length_next = is_dash_next ? cfg.dash_length : cfg.dot_length;
        priority if (!last_in_digit)
        begin
            space_length_next = cfg.element_gap;
        end
        else if (last_mark_next)
        begin
            space_length_next = cfg.end_gap;
        end
        else
        begin
            space_length_next = cfg.digit_gap;
        end

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_stall)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = 1'b0;
        end

        pos_next = pos_reg;
        if (load)
        begin
            pos_next = last_in_digit ? '0 : POS_W'(pos_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mark_length_reg  <= mark_length_next;
            space_length_reg <= space_length_next;
            digit_sent_reg   <= head.digit;
            is_dash_reg      <= is_dash_next;
            last_mark_reg    <= last_mark_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign mark_length  = mark_length_reg;
    assign space_length = space_length_reg;
    assign digit_sent   = digit_sent_reg;
    assign is_dash      = is_dash_reg;
    assign last_mark    = last_mark_reg;

    ap_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < POS_W'(MARKS_PER_DIGIT))
        else $error("mark position out of range");

    ap_beat_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(digit_sent_reg)))
        else $error("stalled beat lost");

endmodule

FILE: rtl/decimal_morse_encoder_unit.sv
// ----------------------------------------------------------------------------
// decimal_morse_encoder_unit
// sends the low eight decimal digits of a number as itu morse marks
// ----------------------------------------------------------------------------
// input channel: in_valid / in_stall with number_value. one beat per number.
// output channel: out_valid / out_stall, one beat per mark: mark_length,
//   space_length, digit_sent, is_dash and last_mark (set on the final mark).
// a number with n kept digits (leading zeros dropped, zero sends one digit)
//   gives 5*n beats, most significant digit first.
// config: cfg_write with cfg_index and cfg_data writes one length register;
//   indexes beyond the end_gap register are ignored. write only while idle.
// first beat: after the input beat the bit-serial bcd converter shifts in all
//   32 input bits, then skips each leading zero in turn, pushes the first digit
//   into the queue, and the output register loads it.
// throughput: one mark per cycle on the output while the queue holds digits and
//   out_stall is low; a new number is taken only after the front end has shifted
//   all 32 input bits, pushed or skipped each digit in turn, and waited while the 4-entry
//   digit queue is full, since marks drain it at one digit per five marks.
// reset: all length registers return to their defaults (100, 300, 100, 300, 1),
//   queue and output register are emptied.
// out_stall holds the current beat; the queue then fills and in_stall stays
//   high until the digits drain.
// ----------------------------------------------------------------------------
module decimal_morse_encoder_unit
    import dme_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [LEN_W-1:0]       cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [INPUT_W-1:0]     number_value,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [LEN_W-1:0]       mark_length,
    output logic [LEN_W-1:0]       space_length,
    output logic [DIGIT_W-1:0]     digit_sent,
    output logic                   is_dash,
    output logic                   last_mark
);

    cfg_t         cfg_reg, cfg_next;
    logic         push;
    digit_entry_t push_entry;
    logic         queue_full;
    logic         pop;
    logic         queue_empty;
    digit_entry_t head;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_DOT_LENGTH:  cfg_next.dot_length  = cfg_data;
                REG_DASH_LENGTH: cfg_next.dash_length = cfg_data;
                REG_ELEMENT_GAP: cfg_next.element_gap = cfg_data;
                REG_DIGIT_GAP:   cfg_next.digit_gap   = cfg_data;
                REG_END_GAP:     cfg_next.end_gap     = cfg_data;
                default:         cfg_next             = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dot_length  <= DOT_LENGTH_RST;
            cfg_reg.dash_length <= DASH_LENGTH_RST;
            cfg_reg.element_gap <= ELEM_GAP_RST;
            cfg_reg.digit_gap   <= DIGIT_GAP_RST;
            cfg_reg.end_gap     <= END_GAP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    dme_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .number_value (number_value),
        .push         (push),
        .push_entry   (push_entry),
        .queue_full   (queue_full)
    );

    dme_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .empty      (queue_empty),
        .head       (head)
    );

    dme_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .queue_empty  (queue_empty),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .mark_length  (mark_length),
        .space_length (space_length),
        .digit_sent   (digit_sent),
        .is_dash      (is_dash),
        .last_mark    (last_mark)
    );

endmodule

FILE: verif/tb_decimal_morse_encoder_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_decimal_morse_encoder_unit
// self-checking bench: numbers go in, every morse mark beat is checked
// against a mark list predicted from the current length registers, under
// random sender gaps, receiver stalls and long receiver hold-offs
// ----------------------------------------------------------------------------
module tb_decimal_morse_encoder_unit;
    import dme_pkg::*;

    typedef struct packed {
        logic [LEN_W-1:0]   mark_len;
        logic [LEN_W-1:0]   space_len;
        logic [DIGIT_W-1:0] digit;
        logic               dash;
        logic               last;
    } mark_t;

    typedef enum int {
        IDLE_NONE,
        IDLE_RANDOM,
        IDLE_BURSTY
    } idle_mode_t;

    localparam int      RANDOM_PER_PHASE = 24;
    localparam int      HOLD_CYCLES      = 400;
    localparam realtime WATCHDOG         = 3_000_000ns;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   cfg_write    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [LEN_W-1:0]       cfg_data     = '0;
    logic                   in_valid     = 1'b0;
    logic [INPUT_W-1:0]     number_value = '0;
    logic                   out_stall    = 1'b0;
    logic                   in_stall;
    logic                   out_valid;
    logic [LEN_W-1:0]       mark_length;
    logic [LEN_W-1:0]       space_length;
    logic [DIGIT_W-1:0]     digit_sent;
    logic                   is_dash;
    logic                   last_mark;

    cfg_t               lengths;
    logic [INPUT_W-1:0] number_queue [$];
    mark_t              marks_due [$];
    mark_t              due_mark;
    idle_mode_t         send_mode   = IDLE_NONE;
    idle_mode_t         recv_mode   = IDLE_NONE;
    logic               in_hit      = 1'b0;
    int                 errors      = 0;
    int                 mark_beats  = 0;
    int                 burst_left  = 0;
    int                 gap_left    = 0;
    int                 hold_left   = 0;
    int                 hold_count  = 0;
    int                 run_left    = 0;
    logic               run_on      = 1'b0;

    decimal_morse_encoder_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .number_value (number_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .mark_length  (mark_length),
        .space_length (space_length),
        .digit_sent   (digit_sent),
        .is_dash      (is_dash),
        .last_mark    (last_mark)
    );

    always #5 clk = ~clk;

    // low kept digits, leading zeros dropped, five marks per digit
    function automatic void expand_number(input logic [INPUT_W-1:0] num);
        logic [DIGIT_W-1:0] dig [NUM_DIGITS];
        logic [INPUT_W-1:0] rest;
        int                 first;
        logic               dash;
        mark_t              m;
        rest  = num;
        first = NUM_DIGITS - 1;
        for (int i = NUM_DIGITS - 1; i >= 0; i--)
        begin
            dig[i] = DIGIT_W'(rest % 10);
            rest   = rest / 10;
        end
        for (int i = NUM_DIGITS - 1; i >= 0; i--)
        begin
            if (dig[i] != '0)
            begin
                first = i;
            end
        end
        for (int i = first; i < NUM_DIGITS; i++)
        begin
            for (int pos = 0; pos < MARKS_PER_DIGIT; pos++)
            begin
                if (int'(dig[i]) <= 5)
                begin
                    dash = (pos >= int'(dig[i]));
                end
                else
                begin
                    dash = (pos < int'(dig[i]) - 5);
                end
                m.mark_len = dash ? lengths.dash_length : lengths.dot_length;
                m.digit    = dig[i];
                m.dash     = dash;
                m.last     = (i == NUM_DIGITS - 1) && (pos == MARKS_PER_DIGIT - 1);
                if (pos != MARKS_PER_DIGIT - 1)
                begin
                    m.space_len = lengths.element_gap;
                end
                else if (m.last)
                begin
                    m.space_len = lengths.end_gap;
                end
                else
                begin
                    m.space_len = lengths.digit_gap;
                end
                marks_due.push_back(m);
            end
        end
    endfunction

    function automatic logic [INPUT_W-1:0] random_number();
        logic [INPUT_W-1:0] value;
        value = '0;
        case ($urandom_range(0, 4))
            0: value = $urandom();
            1: value = $urandom_range(0, 99);
            2: value = $urandom_range(0, 99999999);
            3:
            begin
                // sparse digits plus junk above the kept digits
                for (int i = 0; i < NUM_DIGITS; i++)
                begin
                    value = value * 10 + ($urandom_range(0, 1) ? $urandom_range(0, 9) : 0);
                end
                value = value + 100000000 * $urandom_range(0, 42);
            end
            default: value = $urandom_range(0, 9999);
        endcase
        return value;
    endfunction

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t mismatch on %s: expected %0d, actual %0d", $time, field, want, got);
            errors = errors + 1;
        end
    endtask

    task automatic write_length(input logic [CFG_INDEX_W-1:0] idx, input logic [LEN_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (cfg_reg_t'(idx))
            REG_DOT_LENGTH:  lengths.dot_length  = val;
            REG_DASH_LENGTH: lengths.dash_length = val;
            REG_ELEMENT_GAP: lengths.element_gap = val;
            REG_DIGIT_GAP:   lengths.digit_gap   = val;
            REG_END_GAP:     lengths.end_gap     = val;
            default: ;
        endcase
    endtask

    task automatic set_lengths(input logic [LEN_W-1:0] dot, input logic [LEN_W-1:0] dash,
                               input logic [LEN_W-1:0] elem, input logic [LEN_W-1:0] dgap,
                               input logic [LEN_W-1:0] egap);
        write_length(REG_DOT_LENGTH, dot);
        write_length(REG_DASH_LENGTH, dash);
        write_length(REG_ELEMENT_GAP, elem);
        write_length(REG_DIGIT_GAP, dgap);
        write_length(REG_END_GAP, egap);
    endtask

    // wait until every number went in and every mark came out
    task automatic drain();
        @(posedge clk);
        while (number_queue.size() != 0 || in_valid || marks_due.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // sender
    always @(negedge clk)
    begin
        if (!in_valid || in_hit)
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (number_queue.size() > 0)
            begin
                in_valid     <= 1'b1;
                number_value <= number_queue.pop_front();
                if (send_mode != IDLE_NONE)
                begin
                    if (burst_left == 0)
                    begin
                        burst_left <= $urandom_range(1, 6);
                        gap_left   <= (send_mode == IDLE_RANDOM) ? $urandom_range(0, 3)
                                                                 : $urandom_range(5, 40);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if ((hold_count == 0 && mark_beats >= 150) ||
                 (hold_count == 1 && mark_beats >= 2500))
        begin
            out_stall  <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            hold_count <= hold_count + 1;
        end
        else
        begin
            case (recv_mode)
                IDLE_NONE:   out_stall <= 1'b0;
                IDLE_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
                default:
                begin
                    if (run_left == 0)
                    begin
                        run_on    <= !run_on;
                        run_left  <= $urandom_range(1, 8);
                        out_stall <= !run_on;
                    end
                    else
                    begin
                        run_left  <= run_left - 1;
                        out_stall <= run_on;
                    end
                end
            endcase
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin
        in_hit <= in_valid && !in_stall;
        if (in_valid && !in_stall)
        begin
            expand_number(number_value);
        end
        if (out_valid && !out_stall)
        begin
            mark_beats <= mark_beats + 1;
            if (marks_due.size() == 0)
            begin
                $display("%0t unexpected mark beat: expected none, actual digit %0d",
                         $time, digit_sent);
                errors = errors + 1;
            end
            else
            begin
                due_mark = marks_due.pop_front();
                check_field("mark_length", due_mark.mark_len, mark_length);
                check_field("space_length", due_mark.space_len, space_length);
                check_field("digit_sent", due_mark.digit, digit_sent);
                check_field("is_dash", due_mark.dash, is_dash);
                check_field("last_mark", due_mark.last, last_mark);
            end
        end
    end

    initial
    begin
        logic [INPUT_W-1:0] corners [$] = '{
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 12345678, 87654321, 99999999,
            100000000, 10000000, 90000001, 50505050, 32'hFFFFFFFF, 32'h80000000,
            1234567890, 100000009, 3000000000
        };
        lengths = '{DOT_LENGTH_RST, DASH_LENGTH_RST, ELEM_GAP_RST, DIGIT_GAP_RST, END_GAP_RST};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_mode = IDLE_RANDOM;
        recv_mode = IDLE_RANDOM;
        foreach (corners[i])
        begin
            number_queue.push_back(corners[i]);
        end
        drain();

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:
                begin
                    set_lengths('1, '1, '1, '1, '1);
                    // writes past the last register must be dropped
                    for (int k = int'(REG_END_GAP) + 1; k < (1 << CFG_INDEX_W); k++)
                    begin
                        write_length(CFG_INDEX_W'(k), LEN_W'($urandom()));
                    end
                    send_mode = IDLE_NONE;
                    recv_mode = IDLE_NONE;
                end
                1:
                begin
                    set_lengths('0, '0, '0, '0, '0);
                    send_mode = IDLE_BURSTY;
                    recv_mode = IDLE_BURSTY;
                end
                2:
                begin
                    set_lengths(1, 1, 1, 1, 0);
                    send_mode = IDLE_RANDOM;
                    recv_mode = IDLE_RANDOM;
                end
                default:
                begin
                    set_lengths(LEN_W'($urandom()), LEN_W'($urandom()), LEN_W'($urandom()),
                                LEN_W'($urandom()), LEN_W'($urandom()));
                    send_mode = (phase == 3) ? IDLE_BURSTY : IDLE_RANDOM;
                    recv_mode = (phase == 3) ? IDLE_RANDOM : IDLE_BURSTY;
                end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                number_queue.push_back(random_number());
            end
            drain();
        end

        repeat (60) @(posedge clk);
        if (errors == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial
    begin
        #(WATCHDOG);
        $display("TB_ERROR");
        $finish;
    end

endmodule
